FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ils_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list store package
// Item types, op and status codes, and cell control shared by the RTL.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int POS_CMP_W      = 13;
  localparam int OUT_DATA_W     = 32;

  typedef enum logic [3:0] {
    OP_APPEND       = 4'd0,
    OP_PREPEND      = 4'd1,
    OP_INSERT_AT    = 4'd2,
    OP_REMOVE_FIRST = 4'd3,
    OP_REMOVE_LAST  = 4'd4,
    OP_REMOVE_AT    = 4'd5,
    OP_GET_AT       = 4'd6,
    OP_GET_FIRST    = 4'd7,
    OP_GET_LAST     = 4'd8,
    OP_SET_AT       = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]         op;
    logic [6:0]         position;
    logic signed [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic [6:0]         count;
  } out_item_t;

  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic                 wr;
    logic [POS_CMP_W-1:0] pos;
  } cell_ctrl_t;

endpackage

FILE: sv/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// Indexed list store
// Bounded ordered list of signed words kept in a shifting row of cells.
// ----------------------------------------------------------------------------
// The result is registered in the cycle after the item is accepted.
// Throughput: 1 item per cycle while in_stall is low; the cell row shifts in the accept cycle.
// in_stall is high only while a result waits under out_stall.
// Reset clears the word count and output valid; cell words are left as is.
`include "assert_macros.svh"

module indexed_list_store_top #(
  parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = ils_pkg::WORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ils_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ils_pkg::out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = ils_pkg::POS_CMP_W;
  localparam int DW    = ils_pkg::OUT_DATA_W;

  logic [CNT_W-1:0]      cnt_r;
  logic [PW-1:0]         cnt_ext;
  logic [PW-1:0]         cnt_nxt;
  logic [PW-1:0]         pos_ext;
  logic [PW-1:0]         eff_pos;
  logic                  full;
  logic                  accept;
  logic                  ins;
  logic                  rem;
  logic                  wr;
  logic                  rd;
  ils_pkg::status_t      st;
  ils_pkg::cell_ctrl_t   ctrl;
  logic [WORD_WIDTH-1:0] din_w;
  logic [WORD_WIDTH-1:0] rd_bus;
  logic [DW-1:0]         rd_ext;
  logic [WORD_WIDTH-1:0] words   [CAPACITY];
  logic [WORD_WIDTH-1:0] rd_words[CAPACITY];

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  ils_pkg::out_item_t    out_r;
  ils_pkg::out_item_t    out_nxt;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign cnt_ext  = PW'(cnt_r);
  assign pos_ext  = PW'(in_item.position);
  assign full     = (cnt_ext == PW'(CAPACITY));

  generate
    if (WORD_WIDTH >= DW) begin : g_wide
      assign din_w  = WORD_WIDTH'(in_item.data_in);
      assign rd_ext = rd_bus[DW-1:0];
    end else begin : g_narrow
      assign din_w  = in_item.data_in[WORD_WIDTH-1:0];
      assign rd_ext = {{(DW-WORD_WIDTH){rd_bus[WORD_WIDTH-1]}}, rd_bus};
    end
  endgenerate

  always_comb begin
    eff_pos = pos_ext;
    st      = ils_pkg::ST_RANGE;
    ins     = 1'b0;
    rem     = 1'b0;
    wr      = 1'b0;
    rd      = 1'b0;
    case (ils_pkg::op_t'(in_item.op))
      ils_pkg::OP_APPEND, ils_pkg::OP_PREPEND, ils_pkg::OP_INSERT_AT: begin
        if (ils_pkg::op_t'(in_item.op) == ils_pkg::OP_APPEND) begin
          eff_pos = cnt_ext;
        end else if (ils_pkg::op_t'(in_item.op) == ils_pkg::OP_PREPEND) begin
          eff_pos = '0;
        end
        if (eff_pos > cnt_ext) begin
          st = ils_pkg::ST_RANGE;
        end else if (full) begin
          st = ils_pkg::ST_FULL;
        end else begin
          st  = ils_pkg::ST_OK;
          ins = 1'b1;
        end
      end
      ils_pkg::OP_REMOVE_FIRST, ils_pkg::OP_GET_FIRST: begin
        eff_pos = '0;
        if (cnt_ext != '0) begin
          st  = ils_pkg::ST_OK;
          rd  = 1'b1;
          rem = (ils_pkg::op_t'(in_item.op) == ils_pkg::OP_REMOVE_FIRST);
        end
      end
      ils_pkg::OP_REMOVE_LAST, ils_pkg::OP_GET_LAST: begin
        eff_pos = cnt_ext - PW'(1);
        if (cnt_ext != '0) begin
          st  = ils_pkg::ST_OK;
          rd  = 1'b1;
          rem = (ils_pkg::op_t'(in_item.op) == ils_pkg::OP_REMOVE_LAST);
        end
      end
      ils_pkg::OP_REMOVE_AT, ils_pkg::OP_GET_AT, ils_pkg::OP_SET_AT: begin
        if (pos_ext < cnt_ext) begin
          st  = ils_pkg::ST_OK;
          rd  = 1'b1;
          rem = (ils_pkg::op_t'(in_item.op) == ils_pkg::OP_REMOVE_AT);
          wr  = (ils_pkg::op_t'(in_item.op) == ils_pkg::OP_SET_AT);
        end
      end
      default: begin
        st = ils_pkg::ST_RANGE;
      end
    endcase
  end

  assign ctrl.ins = ins & accept;
  assign ctrl.rem = rem & accept;
  assign ctrl.wr  = wr & accept;
  assign ctrl.pos = eff_pos;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_w;
      logic [WORD_WIDTH-1:0] right_w;
      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = words[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = words[gi+1];
      end
      ils_cell #(
        .IDX        (gi),
        .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .din        (din_w),
        .left_word  (left_w),
        .right_word (right_w),
        .word       (words[gi]),
        .rd_word    (rd_words[gi])
      );
    end
  endgenerate

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | rd_words[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_ext;
    if (ins) begin
      cnt_nxt = cnt_ext + PW'(1);
    end else if (rem) begin
      cnt_nxt = cnt_ext - PW'(1);
    end
    out_nxt.data_out = (rd && (st == ils_pkg::ST_OK)) ? rd_ext : '0;
    out_nxt.status   = st;
    out_nxt.count    = cnt_nxt[6:0];
    out_valid_nxt    = out_valid_r & out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_ALWAYS(a_cnt_bound, cnt_ext <= PW'(CAPACITY), "count exceeds capacity")
  `ASSERT_NEXT(a_add_cnt, accept && ins, cnt_ext == $past(cnt_ext) + PW'(1), "add lost count")
  `ASSERT_NEXT(a_err_hold, accept && (st != ils_pkg::ST_OK), $stable(cnt_r), "refused item changed count")
  `ASSERT_ALWAYS(a_err_zero, !out_valid_r || (out_r.status == ils_pkg::ST_OK) || (out_r.data_out == '0), "error result carries data")

endmodule

FILE: sv/ils_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one word; shifts from its left or right neighbor on insert or remove.
// ----------------------------------------------------------------------------
module ils_cell #(
  parameter int IDX        = 0,
  parameter int WORD_WIDTH = ils_pkg::WORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  ils_pkg::cell_ctrl_t    ctrl,
  input  logic [WORD_WIDTH-1:0]  din,
  input  logic [WORD_WIDTH-1:0]  left_word,
  input  logic [WORD_WIDTH-1:0]  right_word,
  output logic [WORD_WIDTH-1:0]  word,
  output logic [WORD_WIDTH-1:0]  rd_word
);

  localparam logic [ils_pkg::POS_CMP_W-1:0] IDX_C = ils_pkg::POS_CMP_W'(IDX);

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.ins) begin
      if (IDX_C > ctrl.pos) begin
        word_nxt = left_word;
      end else if (IDX_C == ctrl.pos) begin
        word_nxt = din;
      end
    end else if (ctrl.rem) begin
      if (IDX_C >= ctrl.pos) begin
        word_nxt = right_word;
      end
    end else if (ctrl.wr && (IDX_C == ctrl.pos)) begin
      word_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign rd_word = (IDX_C == ctrl.pos) ? word_r : '0;

endmodule

FILE: dv/tb_indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// Indexed list store testbench
// Drives list requests through the valid/stall input channel and checks each
// result against a queue-based list model kept in the bench. Covers empty and
// full stores, out-of-range positions, unused op codes, and a random walk of
// the word count with idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_top;

  localparam int          STORE_DEPTH  = ils_pkg::CAPACITY_DEF;
  localparam logic [3:0]  OP_UNUSED_LO = 4'd10;
  localparam logic [3:0]  OP_UNUSED_HI = 4'd15;
  localparam logic [6:0]  POS_MAX      = 7'd127;
  localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] WORD_ONES    = 32'hffff_ffff;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ils_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ils_pkg::out_item_t out_item;

  logic signed [31:0] list_words[$];
  ils_pkg::out_item_t pending_results[$];
  int                 mismatches = 0;
  int                 stall_left = 0;
  bit                 idle_on    = 1'b1;

  indexed_list_store_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("indexed_list_store_top test failed");
    $finish;
  end

  function automatic ils_pkg::status_t add_word(int at, logic signed [31:0] w);
    if (at > list_words.size()) return ils_pkg::ST_RANGE;
    if (list_words.size() >= STORE_DEPTH) return ils_pkg::ST_FULL;
    list_words.insert(at, w);
    return ils_pkg::ST_OK;
  endfunction

  function automatic ils_pkg::status_t take_word(int at, output logic signed [31:0] w);
    w = '0;
    if (at < 0 || at >= list_words.size()) return ils_pkg::ST_RANGE;
    w = list_words[at];
    list_words.delete(at);
    return ils_pkg::ST_OK;
  endfunction

  function automatic ils_pkg::out_item_t apply_request(ils_pkg::in_item_t req);
    ils_pkg::out_item_t res;
    int                 n;
    int                 pos;
    n            = list_words.size();
    pos          = int'(req.position);
    res.data_out = '0;
    res.status   = ils_pkg::ST_RANGE;
    case (req.op)
      ils_pkg::OP_APPEND:       res.status = add_word(n, req.data_in);
      ils_pkg::OP_PREPEND:      res.status = add_word(0, req.data_in);
      ils_pkg::OP_INSERT_AT:    res.status = add_word(pos, req.data_in);
      ils_pkg::OP_REMOVE_FIRST: res.status = take_word(0, res.data_out);
      ils_pkg::OP_REMOVE_LAST:  res.status = take_word(n - 1, res.data_out);
      ils_pkg::OP_REMOVE_AT:    res.status = take_word(pos, res.data_out);
      ils_pkg::OP_GET_AT: begin
        if (pos < n) begin
          res.data_out = list_words[pos];
          res.status   = ils_pkg::ST_OK;
        end
      end
      ils_pkg::OP_GET_FIRST: begin
        if (n > 0) begin
          res.data_out = list_words[0];
          res.status   = ils_pkg::ST_OK;
        end
      end
      ils_pkg::OP_GET_LAST: begin
        if (n > 0) begin
          res.data_out = list_words[n - 1];
          res.status   = ils_pkg::ST_OK;
        end
      end
      ils_pkg::OP_SET_AT: begin
        if (pos < n) begin
          res.data_out    = list_words[pos];
          list_words[pos] = req.data_in;
          res.status      = ils_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    if (res.status != ils_pkg::ST_OK) res.data_out = '0;
    res.count = 7'(list_words.size());
    return res;
  endfunction

  task automatic check_result(ils_pkg::out_item_t got);
    ils_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected item: expected none, got data_out %0d status %0d count %0d",
               $time, got.data_out, got.status, got.count);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (got.data_out !== want.data_out) begin
        $display("%0t: data_out expected %0d, got %0d", $time, want.data_out, got.data_out);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
        mismatches++;
      end
    end
  endtask

  // result side: check accepted items, then pick out_stall for the next cycle
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) check_result(out_item);
    if (!idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = int'($urandom_range(1, 11)) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic issue_request(logic [3:0] op, logic [6:0] pos, logic [31:0] word);
    ils_pkg::in_item_t req;
    req.op       = op;
    req.position = pos;
    req.data_in  = word;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(apply_request(req));
  endtask

  function automatic logic [3:0] pick_op(int add_pct, int rem_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_UNUSED_LO + 4'($urandom_range(0, 5));
    if (roll < 3 + add_pct) begin
      case ($urandom_range(0, 2))
        0:       return ils_pkg::OP_APPEND;
        1:       return ils_pkg::OP_PREPEND;
        default: return ils_pkg::OP_INSERT_AT;
      endcase
    end
    if (roll < 3 + add_pct + rem_pct) begin
      case ($urandom_range(0, 2))
        0:       return ils_pkg::OP_REMOVE_FIRST;
        1:       return ils_pkg::OP_REMOVE_LAST;
        default: return ils_pkg::OP_REMOVE_AT;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return ils_pkg::OP_GET_AT;
      1:       return ils_pkg::OP_GET_FIRST;
      2:       return ils_pkg::OP_GET_LAST;
      default: return ils_pkg::OP_SET_AT;
    endcase
  endfunction

  // mostly in range; now and then anywhere in the 7-bit field
  function automatic logic [6:0] pick_position(logic [3:0] op);
    int n;
    n = list_words.size();
    if ($urandom_range(0, 6) == 0) return 7'($urandom_range(0, POS_MAX));
    if (op == ils_pkg::OP_INSERT_AT) return 7'($urandom_range(0, n));
    if (n == 0) return '0;
    return 7'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        2:       return WORD_ONES;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic issue_random(int add_pct, int rem_pct);
    logic [3:0] op;
    op = pick_op(add_pct, rem_pct);
    issue_request(op, pick_position(op), pick_word());
  endtask

  task automatic reset_dut();
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_directed();
    issue_request(ils_pkg::OP_REMOVE_FIRST, '0, WORD_ONES);
    issue_request(ils_pkg::OP_REMOVE_LAST, '0, WORD_ONES);
    issue_request(ils_pkg::OP_REMOVE_AT, '0, WORD_ONES);
    issue_request(ils_pkg::OP_GET_FIRST, '0, '0);
    issue_request(ils_pkg::OP_GET_LAST, '0, '0);
    issue_request(ils_pkg::OP_GET_AT, '0, '0);
    issue_request(ils_pkg::OP_SET_AT, '0, WORD_MAX);
    issue_request(ils_pkg::OP_APPEND, POS_MAX, WORD_MAX);
    issue_request(ils_pkg::OP_PREPEND, POS_MAX, WORD_MIN);
    issue_request(ils_pkg::OP_INSERT_AT, 7'd1, WORD_ONES);
    issue_request(ils_pkg::OP_INSERT_AT, 7'd3, '0);          // position == count appends
    issue_request(ils_pkg::OP_INSERT_AT, 7'd5, 32'h1234_5678);
    issue_request(ils_pkg::OP_GET_AT, 7'd2, '0);
    issue_request(ils_pkg::OP_GET_AT, POS_MAX, '0);
    issue_request(ils_pkg::OP_SET_AT, 7'd1, 32'h5a5a_5a5a);
    issue_request(ils_pkg::OP_GET_FIRST, '0, '0);
    issue_request(ils_pkg::OP_GET_LAST, '0, '0);
    issue_request(ils_pkg::OP_REMOVE_AT, 7'd1, '0);
    issue_request(ils_pkg::OP_REMOVE_AT, 7'd3, '0);
    issue_request(ils_pkg::OP_REMOVE_LAST, '0, '0);
    issue_request(OP_UNUSED_LO, POS_MAX, WORD_ONES);
    issue_request(OP_UNUSED_HI, POS_MAX, WORD_ONES);
    issue_request(ils_pkg::OP_REMOVE_FIRST, '0, '0);
    issue_request(ils_pkg::OP_REMOVE_FIRST, '0, '0);
  endtask

  task automatic test_fill_and_drain();
    logic [3:0] op;
    idle_on = 1'b1;
    while (list_words.size() < STORE_DEPTH) begin
      op = pick_op(97, 0);
      issue_request(op, pick_position(op), pick_word());
    end
    issue_request(ils_pkg::OP_APPEND, '0, pick_word());
    issue_request(ils_pkg::OP_PREPEND, '0, pick_word());
    issue_request(ils_pkg::OP_INSERT_AT, 7'(STORE_DEPTH), pick_word());
    issue_request(ils_pkg::OP_INSERT_AT, 7'(STORE_DEPTH + 1), pick_word());
    issue_request(ils_pkg::OP_INSERT_AT, POS_MAX, pick_word());
    issue_request(ils_pkg::OP_GET_AT, 7'(STORE_DEPTH - 1), '0);
    issue_request(ils_pkg::OP_SET_AT, 7'(STORE_DEPTH - 1), pick_word());
    issue_request(ils_pkg::OP_GET_AT, 7'(STORE_DEPTH), '0);
    issue_request(ils_pkg::OP_GET_LAST, '0, '0);
    while (list_words.size() > 0) begin
      op = pick_op(0, 97);
      issue_request(op, pick_position(op), pick_word());
    end
  endtask

  task automatic test_random_walk();
    for (int seg = 0; seg < 12; seg++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case (seg % 3)
        0:       repeat (115) issue_random(55, 15);
        1:       repeat (115) issue_random(15, 55);
        default: repeat (115) issue_random(35, 35);
      endcase
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (150) issue_random(35, 35);
  endtask

  initial begin
    reset_dut();
    test_directed();
    test_fill_and_drain();
    test_random_walk();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("indexed_list_store_top test passed");
    end else begin
      $display("indexed_list_store_top test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/ils_pkg.sv
sv/ils_cell.sv
sv/indexed_list_store_top.sv
dv/tb_indexed_list_store_top.sv
